// ----- hdl/rmq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and path codes for the matrix-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam logic [1:0] PATH_TRACE = 2'd0;
  localparam logic [1:0] PATH_FX    = 2'd1;
  localparam logic [1:0] PATH_LY    = 2'd2;
  localparam logic [1:0] PATH_UZ    = 2'd3;

  // item state riding alongside the arithmetic cells
  typedef struct packed {
    logic       vld;
    logic [1:0] path;
    logic       degen;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hdl/rmq_sqrt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit of a pipelined restoring square root; one result bit per cell.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
  parameter int W   = 36,
  parameter int RW  = 18,
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic [W-1:0]  rem_in,
  input  wire logic [RW-1:0] root_in,
  input  wire logic [W-1:0]  arg_in,
  output logic      [W-1:0]  rem_out,
  output logic      [RW-1:0] root_out,
  output logic      [W-1:0]  arg_out
);

  logic [W-1:0]  rem_sh;
  logic [W-1:0]  trial;
  logic [W-1:0]  rem_nxt;
  logic [RW-1:0] root_nxt;

  always_comb begin
    // bring down next two bits of the argument
    rem_sh = {rem_in[W-3:0], arg_in[2*IDX+1 -: 2]};
    trial  = {{(W-RW-2){1'b0}}, root_in, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_in[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_in[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    rem_out  <= rem_nxt;
    root_out <= root_nxt;
    arg_out  <= arg_in;
  end

endmodule
`default_nettype wire

// ----- hdl/rmq_div_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit of three restoring dividers sharing a divisor.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
  parameter int NW  = 40,
  parameter int DW  = 20,
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire logic [DW-1:0]      den_in,
  input  wire logic [2:0][NW-1:0] num_in,
  input  wire logic [2:0][DW:0]   rem_in,
  input  wire logic [2:0][NW-1:0] quo_in,
  output logic      [DW-1:0]      den_out,
  output logic      [2:0][NW-1:0] num_out,
  output logic      [2:0][DW:0]   rem_out,
  output logic      [2:0][NW-1:0] quo_out
);

  logic [2:0][DW+1:0] rs;
  logic [2:0][DW:0]   rem_nxt;
  logic [2:0][NW-1:0] quo_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rs[k] = {rem_in[k], num_in[k][IDX]};
      quo_nxt[k] = quo_in[k];
      if (rs[k] >= {2'b00, den_in}) begin
        rem_nxt[k] = (DW+1)'(rs[k] - {2'b00, den_in});
        quo_nxt[k][IDX] = 1'b1;
      end else begin
        rem_nxt[k] = rs[k][DW:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    den_out <= den_in;
    num_out <= num_in;
    rem_out <= rem_nxt;
    quo_out <= quo_nxt;
  end

endmodule
`default_nettype wire

// ----- hdl/rotation_matrix_to_quaternion.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd matrix-to-quaternion conversion, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one matrix per clock while busy is low (busy is held low: the
// pipeline never stalls). There is no back-pressure on the result side: the
// receiver must take each result in the one cycle that out_valid is high.
// A matrix passes through the input register, the square-root cell row
// (FRAC_BITS+2 cells when FRAC_BITS >= 14, one root bit a cell), the
// divider cell row (FRAC_BITS+19 cells, one quotient bit a cell) and the
// output register.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_fwd_x,
  input  wire logic signed [15:0] in_fwd_y,
  input  wire logic signed [15:0] in_fwd_z,
  input  wire logic signed [15:0] in_left_x,
  input  wire logic signed [15:0] in_left_y,
  input  wire logic signed [15:0] in_left_z,
  input  wire logic signed [15:0] in_up_x,
  input  wire logic signed [15:0] in_up_y,
  input  wire logic signed [15:0] in_up_z,
  output logic                    out_valid,
  output logic signed [15:0]      out_quat_i,
  output logic signed [15:0]      out_quat_j,
  output logic signed [15:0]      out_quat_k,
  output logic signed [15:0]      out_quat_w,
  output logic [1:0]              out_branch_taken,
  output logic                    out_degenerate
);

  // arg < 98304 + ONE: 18 signed bits, or F+4 once ONE dominates
  localparam int AB  = (FRAC_BITS + 4 > 18) ? FRAC_BITS + 4 : 18;
  localparam int AW0 = AB + FRAC_BITS;
  localparam int AW  = AW0 + (AW0 % 2);
  localparam int NS  = AW / 2;
  localparam int RW  = NS + 1;
  localparam int SW  = AW + 2;
  localparam int DW  = NS + 1;             // den = 2*S
  localparam int NW  = 18 + FRAC_BITS + 1; // (|d|<<F) + den/2
  localparam int ND  = NW;
  localparam logic signed [AB-1:0] ONE_A = AB'(1) <<< FRAC_BITS;

  assign busy = 1'b0;

  // ---- stage 0: path select and diff terms
  logic signed [17:0] tr, a_fx, a_ly, a_uz, arg_s;
  logic [1:0]         path;
  logic signed [16:0] d [3];

  always_comb begin
    tr   = 18'(in_fwd_x) + 18'(in_left_y) + 18'(in_up_z);
    a_fx = 18'(in_fwd_x) - 18'(in_left_y) - 18'(in_up_z);
    a_ly = 18'(in_left_y) - 18'(in_fwd_x) - 18'(in_up_z);
    a_uz = 18'(in_up_z) - 18'(in_fwd_x) - 18'(in_left_y);
    if (tr > 0) begin
      path = rmq_pkg::PATH_TRACE; arg_s = tr;
    end else if (in_fwd_x >= in_left_y && in_fwd_x >= in_up_z) begin
      path = rmq_pkg::PATH_FX; arg_s = a_fx;
    end else if (in_left_y > in_up_z) begin
      path = rmq_pkg::PATH_LY; arg_s = a_ly;
    end else begin
      path = rmq_pkg::PATH_UZ; arg_s = a_uz;
    end
    unique case (path)
      rmq_pkg::PATH_TRACE: begin
        d[0] = 17'(in_left_z) - 17'(in_up_y);
        d[1] = 17'(in_up_x) - 17'(in_fwd_z);
        d[2] = 17'(in_fwd_y) - 17'(in_left_x);
      end
      rmq_pkg::PATH_FX: begin
        d[0] = 17'(in_fwd_y) + 17'(in_left_x);
        d[1] = 17'(in_fwd_z) + 17'(in_up_x);
        d[2] = 17'(in_left_z) - 17'(in_up_y);
      end
      rmq_pkg::PATH_LY: begin
        d[0] = 17'(in_left_x) + 17'(in_fwd_y);
        d[1] = 17'(in_up_y) + 17'(in_left_z);
        d[2] = 17'(in_up_x) - 17'(in_fwd_z);
      end
      default: begin
        d[0] = 17'(in_up_x) + 17'(in_fwd_z);
        d[1] = 17'(in_up_y) + 17'(in_left_z);
        d[2] = 17'(in_fwd_y) - 17'(in_left_x);
      end
    endcase
  end

  // stage 1 registers
  rmq_pkg::ctl_t      c1_r;
  logic signed [AB-1:0] arg1_r;
  logic signed [16:0]   d1_r [3];
  logic signed [AB-1:0] arg_full;

  assign arg_full = AB'(arg_s) + ONE_A;

  always_ff @(posedge clk) begin
    if (!rst_n) c1_r.vld <= 1'b0;
    else        c1_r.vld <= start;
    c1_r.path  <= path;
    c1_r.degen <= (arg_full <= 0);
    arg1_r     <= arg_full;
    d1_r       <= d;
  end

  // ---- sqrt cell row, with control/diff delay line alongside
  logic [SW-1:0] sq_rem  [NS+1];
  logic [RW-1:0] sq_root [NS+1];
  logic [SW-1:0] sq_arg  [NS+1];
  rmq_pkg::ctl_t      sc_r [NS+1];
  logic signed [16:0] sd_r [NS+1][3];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_arg[0]  = arg1_r[AB-1] ? '0 :
                      SW'({{(SW-AB){1'b0}}, arg1_r} << FRAC_BITS);
  assign sc_r[0] = c1_r;
  assign sd_r[0] = d1_r;

  for (genvar g = 0; g < NS; g++) begin : g_sq
    rmq_sqrt_cell #(.W(SW), .RW(RW), .IDX(NS-1-g)) u_cell (
      .clk(clk), .rem_in(sq_rem[g]), .root_in(sq_root[g]), .arg_in(sq_arg[g]),
      .rem_out(sq_rem[g+1]), .root_out(sq_root[g+1]), .arg_out(sq_arg[g+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) sc_r[g+1].vld <= 1'b0;
      else        sc_r[g+1].vld <= sc_r[g].vld;
      sc_r[g+1].path  <= sc_r[g].path;
      sc_r[g+1].degen <= sc_r[g].degen;
      sd_r[g+1]       <= sd_r[g];
    end
  end

  // ---- divider setup
  logic [NS-1:0]       s_val;
  logic [DW-1:0]       den;
  logic [2:0][NW-1:0]  num0;
  logic [2:0]          neg0;
  logic [16:0]         mag [3];

  assign s_val = sq_root[NS][NS-1:0];
  assign den   = {s_val, 1'b0};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg0[k] = sd_r[NS][k][16];
      mag[k]  = neg0[k] ? 17'(-sd_r[NS][k]) : 17'(sd_r[NS][k]);
      num0[k] = (NW'(mag[k]) << FRAC_BITS) + NW'(s_val);
    end
  end

  logic [DW-1:0]      dv_den [ND+1];
  logic [2:0][NW-1:0] dv_num [ND+1];
  logic [2:0][DW:0]   dv_rem [ND+1];
  logic [2:0][NW-1:0] dv_quo [ND+1];
  rmq_pkg::ctl_t      dc_r  [ND+1];
  logic [2:0]         dn_r  [ND+1];
  logic [NS-1:0]      ds_r  [ND+1];

  assign dv_den[0] = den;
  assign dv_num[0] = num0;
  assign dv_rem[0] = '0;
  assign dv_quo[0] = '0;
  assign dc_r[0]   = sc_r[NS];
  assign dn_r[0]   = neg0;
  assign ds_r[0]   = s_val;

  for (genvar g = 0; g < ND; g++) begin : g_dv
    rmq_div_cell #(.NW(NW), .DW(DW), .IDX(ND-1-g)) u_cell (
      .clk(clk), .den_in(dv_den[g]), .num_in(dv_num[g]), .rem_in(dv_rem[g]),
      .quo_in(dv_quo[g]), .den_out(dv_den[g+1]), .num_out(dv_num[g+1]),
      .rem_out(dv_rem[g+1]), .quo_out(dv_quo[g+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) dc_r[g+1].vld <= 1'b0;
      else        dc_r[g+1].vld <= dc_r[g].vld;
      dc_r[g+1].path  <= dc_r[g].path;
      dc_r[g+1].degen <= dc_r[g].degen;
      dn_r[g+1]       <= dn_r[g];
      ds_r[g+1]       <= ds_r[g];
    end
  end

  // ---- output: sign, saturate, place
  function automatic logic [15:0] sat_q(input logic [NW-1:0] q, input logic neg);
    logic [15:0] res;
    if (neg) res = (q > NW'(32768)) ? 16'h8000 : 16'(-q);
    else     res = (q > NW'(32767)) ? 16'h7fff : q[15:0];
    return res;
  endfunction

  logic [15:0] o0, o1, o2, half;
  logic [NS:0] half_w;
  rmq_pkg::ctl_t cf;

  assign cf     = dc_r[ND];
  assign half_w = ({1'b0, ds_r[ND]} + 1'b1) >> 1;
  assign half   = (half_w > (NS+1)'(32767)) ? 16'h7fff : 16'(half_w);
  assign o0     = sat_q(dv_quo[ND][0], dn_r[ND][0]);
  assign o1     = sat_q(dv_quo[ND][1], dn_r[ND][1]);
  assign o2     = sat_q(dv_quo[ND][2], dn_r[ND][2]);

  logic [15:0] qi, qj, qk, qw;
  always_comb begin
    unique case (cf.path)
      rmq_pkg::PATH_TRACE: begin qw = half; qi = o0; qj = o1; qk = o2; end
      rmq_pkg::PATH_FX:    begin qi = half; qj = o0; qk = o1; qw = o2; end
      rmq_pkg::PATH_LY:    begin qi = o0; qj = half; qk = o1; qw = o2; end
      default:             begin qi = o0; qj = o1; qk = half; qw = o2; end
    endcase
    if (cf.degen) begin
      qi = '0; qj = '0; qk = '0; qw = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= cf.vld;
    out_quat_i       <= qi;
    out_quat_j       <= qj;
    out_quat_k       <= qk;
    out_quat_w       <= qw;
    out_branch_taken <= cf.path;
    out_degenerate   <= cf.degen;
  end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Matrix-to-quaternion check: random and directed matrices are pushed through
// the pipeline and every result beat is compared with an in-bench prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int FB  = 14;
  localparam int LAT = 2 * FB + 22;
  localparam logic signed [15:0] ONE_Q = 16'sd16384;

  typedef struct {
    logic signed [15:0] m [9];
  } mat_t;

  typedef struct {
    logic signed [15:0] qi, qj, qk, qw;
    logic [1:0]         path;
    logic               degen;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_m [9] = '{default: '0};
  logic out_valid;
  logic signed [15:0] out_quat_i, out_quat_j, out_quat_k, out_quat_w;
  logic [1:0] out_branch_taken;
  logic out_degenerate;

  mat_t  pending_mats [$];
  quat_t expected_quats [$];
  int    errors = 0;
  int    n_sent = 0;
  int    n_checked = 0;
  int    path_hits [4] = '{0, 0, 0, 0};
  int    n_degen = 0;
  bit    hold_drain = 0;
  int    gap = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rotation_matrix_to_quaternion #(.FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_fwd_x(in_m[0]), .in_fwd_y(in_m[1]), .in_fwd_z(in_m[2]),
    .in_left_x(in_m[3]), .in_left_y(in_m[4]), .in_left_z(in_m[5]),
    .in_up_x(in_m[6]), .in_up_y(in_m[7]), .in_up_z(in_m[8]),
    .out_valid(out_valid), .out_quat_i(out_quat_i), .out_quat_j(out_quat_j),
    .out_quat_k(out_quat_k), .out_quat_w(out_quat_w),
    .out_branch_taken(out_branch_taken), .out_degenerate(out_degenerate)
  );

  function automatic longint clamp16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint root_floor(longint v);
    longint r;
    r = longint'($sqrt(real'(v)));
    while (r * r > v) r--;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // d * 2^F / (2s), round half away from zero
  function automatic longint div_by_root(longint d, longint s);
    longint den, mag, q;
    den = 2 * s;
    mag = (d < 0) ? -d : d;
    q = ((mag <<< FB) + (den >>> 1)) / den;
    return clamp16((d < 0) ? -q : q);
  endfunction

  function automatic quat_t shepperd(mat_t a);
    quat_t r;
    longint fx, fy, fz, lx, ly, lz, ux, uy, uz, tr, arg, s, half;
    fx = a.m[0]; fy = a.m[1]; fz = a.m[2];
    lx = a.m[3]; ly = a.m[4]; lz = a.m[5];
    ux = a.m[6]; uy = a.m[7]; uz = a.m[8];
    tr = fx + ly + uz;
    r.qi = '0; r.qj = '0; r.qk = '0; r.qw = '0; r.degen = 1'b0;
    if (tr > 0) begin
      r.path = rmq_pkg::PATH_TRACE; arg = tr + (1 <<< FB);
    end else if (fx >= ly && fx >= uz) begin
      r.path = rmq_pkg::PATH_FX; arg = (1 <<< FB) + fx - ly - uz;
    end else if (ly > uz) begin
      r.path = rmq_pkg::PATH_LY; arg = (1 <<< FB) + ly - fx - uz;
    end else begin
      r.path = rmq_pkg::PATH_UZ; arg = (1 <<< FB) + uz - fx - ly;
    end
    if (arg <= 0) begin
      r.degen = 1'b1;
      return r;
    end
    s = root_floor(arg <<< FB);
    half = clamp16((s + 1) >>> 1);
    case (r.path)
      rmq_pkg::PATH_TRACE: begin
        r.qw = 16'(half); r.qi = 16'(div_by_root(lz - uy, s));
        r.qj = 16'(div_by_root(ux - fz, s)); r.qk = 16'(div_by_root(fy - lx, s));
      end
      rmq_pkg::PATH_FX: begin
        r.qi = 16'(half); r.qj = 16'(div_by_root(fy + lx, s));
        r.qk = 16'(div_by_root(fz + ux, s)); r.qw = 16'(div_by_root(lz - uy, s));
      end
      rmq_pkg::PATH_LY: begin
        r.qi = 16'(div_by_root(lx + fy, s)); r.qj = 16'(half);
        r.qk = 16'(div_by_root(uy + lz, s)); r.qw = 16'(div_by_root(ux - fz, s));
      end
      default: begin
        r.qi = 16'(div_by_root(ux + fz, s)); r.qj = 16'(div_by_root(uy + lz, s));
        r.qk = 16'(half); r.qw = 16'(div_by_root(fy - lx, s));
      end
    endcase
    return r;
  endfunction

  // driver: one beat per accepted start, random gaps between beats
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_quats.push_back(shepperd(pending_mats.pop_front()));
        n_sent <= n_sent + 1;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end
      if (!(start && busy)) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (hold_drain && expected_quats.size() != 0) begin
          start <= 1'b0;
        end else if (pending_mats.size() != 0) begin
          start <= 1'b1;
          for (int k = 0; k < 9; k++) in_m[k] <= pending_mats[0].m[k];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    quat_t e;
    if (rst_n && out_valid) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        e = expected_quats.pop_front();
        n_checked++;
        path_hits[e.path]++;
        if (e.degen) n_degen++;
        if (out_quat_i !== e.qi || out_quat_j !== e.qj || out_quat_k !== e.qk ||
            out_quat_w !== e.qw || out_branch_taken !== e.path ||
            out_degenerate !== e.degen) begin
          $display("%0t: mismatch exp q=(%0d %0d %0d %0d) path %0d degen %0d",
                   $time, e.qi, e.qj, e.qk, e.qw, e.path, e.degen);
          $display("%0t:          got q=(%0d %0d %0d %0d) path %0d degen %0d",
                   $time, out_quat_i, out_quat_j, out_quat_k, out_quat_w,
                   out_branch_taken, out_degenerate);
          errors++;
        end
      end
    end
  end

  function automatic mat_t diag(int a, int b, int c);
    mat_t r;
    foreach (r.m[k]) r.m[k] = '0;
    r.m[0] = 16'(a); r.m[4] = 16'(b); r.m[8] = 16'(c);
    return r;
  endfunction

  // roughly orthonormal matrix from a random unit-ish quaternion
  function automatic mat_t near_rotation();
    mat_t r;
    real w, x, y, z, n;
    real e [9];
    w = $urandom_range(0, 2000) - 1000.0; x = $urandom_range(0, 2000) - 1000.0;
    y = $urandom_range(0, 2000) - 1000.0; z = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(w * w + x * x + y * y + z * z);
    if (n < 1.0) n = 1.0;
    w /= n; x /= n; y /= n; z /= n;
    e = '{1 - 2 * (y * y + z * z), 2 * (x * y + w * z), 2 * (x * z - w * y),
          2 * (x * y - w * z), 1 - 2 * (x * x + z * z), 2 * (y * z + w * x),
          2 * (x * z + w * y), 2 * (y * z - w * x), 1 - 2 * (x * x + y * y)};
    foreach (e[k])
      r.m[k] = 16'(clamp16($rtoi(e[k] * 16384.0) + $signed($urandom_range(0, 8)) - 4));
    return r;
  endfunction

  initial begin
    mat_t a;
    // directed: identity, half-turns, path ties, extremes, zero and small diagonals
    pending_mats.push_back(diag(ONE_Q, ONE_Q, ONE_Q));
    pending_mats.push_back(diag(ONE_Q, -ONE_Q, -ONE_Q));
    pending_mats.push_back(diag(-ONE_Q, ONE_Q, -ONE_Q));
    pending_mats.push_back(diag(-ONE_Q, -ONE_Q, ONE_Q));
    pending_mats.push_back(diag(0, 0, 0));
    pending_mats.push_back(diag(-100, -100, -100));
    pending_mats.push_back(diag(-200, -100, -100));
    pending_mats.push_back(diag(-32768, -32768, -32768));
    pending_mats.push_back(diag(32767, 32767, 32767));
    pending_mats.push_back(diag(-32768, 32767, 32767));
    pending_mats.push_back(diag(-20000, -32768, -32768));
    pending_mats.push_back(diag(-32768, -32768, -20000));
    pending_mats.push_back(diag(-32768, -20000, -32768));
    pending_mats.push_back(diag(1, -32768, 0));
    for (int k = 0; k < 6; k++) begin
      foreach (a.m[j]) a.m[j] = (k[0]) ? 16'sh7fff : 16'sh8000;
      if (k >= 2) a = diag(k[1] ? -16384 : -32768, -32768, -32768);
      if (k >= 2) foreach (a.m[j]) if (j % 4 != 0) a.m[j] = (j + k) % 2 ? 16'sh7fff : 16'sh8000;
      pending_mats.push_back(a);
    end
    // random: mostly near-rotations, rest raw bit patterns or weak diagonals
    for (int n = 0; n < 650; n++) begin
      case ($urandom_range(0, 9))
        0, 1: foreach (a.m[k]) a.m[k] = 16'($urandom());
        2: begin
          foreach (a.m[k]) a.m[k] = 16'($urandom());
          a.m[0] = 16'($signed($urandom_range(0, 8000)) - 12000);
          a.m[4] = 16'($signed($urandom_range(0, 8000)) - 12000);
          a.m[8] = 16'($signed($urandom_range(0, 8000)) - 12000);
        end
        default: a = near_rotation();
      endcase
      pending_mats.push_back(a);
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // drain pause partway through
    wait (n_sent >= 300);
    hold_drain = 1;
    wait (expected_quats.size() == 0);
    hold_drain = 0;

    wait (pending_mats.size() == 0 && !start);
    wait (expected_quats.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    $display("Sent %0d matrices, checked %0d quaternions, %0d degenerate.",
             n_sent, n_checked, n_degen);
    $display("Paths: trace %0d, fwd-x %0d, left-y %0d, up-z %0d.",
             path_hits[0], path_hits[1], path_hits[2], path_hits[3]);
    if (errors == 0 && expected_quats.size() == 0)
      $display("rotation_matrix_to_quaternion test passed");
    else
      $display("rotation_matrix_to_quaternion test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("rotation_matrix_to_quaternion test failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/rmq_pkg.sv
hdl/rmq_sqrt_cell.sv
hdl/rmq_div_cell.sv
hdl/rotation_matrix_to_quaternion.sv
sim/tb.sv
